// File: hw/rtl/sliding_window_trend_estimator_top_assert.svh
// ----------------------------------------------------------------------------
// Trend estimator assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_TREND_ESTIMATOR_TOP_ASSERT_SVH
`define SLIDING_WINDOW_TREND_ESTIMATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SWTE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("trend estimator check failed");
`define SWTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("trend estimator check failed");
`else
`define SWTE_ASSERT_IMPL(label, ante, cons)
`define SWTE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/swte_pkg.sv
// ----------------------------------------------------------------------------
// Trend estimator package
// Widths, register indexes, class codes and per-fill constant tables.
// ----------------------------------------------------------------------------
package swte_pkg;

	localparam int WINDOW      = 30;
	localparam int SAMPLE_BITS = 16;
	localparam int FILL_W      = $clog2(WINDOW + 1);
	localparam int PTR_W       = $clog2(WINDOW);
	localparam int SY_W        = 22;
	localparam int SXY_W       = 27;
	localparam int NUM_W       = 32;
	localparam int D_W         = 17;
	localparam int TWOD_W      = 22;
	localparam int K1_W        = 10;
	localparam int K2_W        = 14;
	localparam int DIV_W       = 48;
	localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
	localparam int SPM_W       = 6;
	localparam int THR_W       = 16;
	localparam int HOR_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int SLOPE_W     = 32;
	localparam int CLS_W       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOR = 2'd2;

	localparam logic [SPM_W-1:0] SPM_RST = 6'd6;
	localparam logic [THR_W-1:0] THR_RST = 16'd1280;
	localparam logic [HOR_W-1:0] HOR_RST = 7'd30;

	localparam logic [CLS_W-1:0] CLS_STABLE = 2'd0;
	localparam logic [CLS_W-1:0] CLS_RISE   = 2'd1;
	localparam logic [CLS_W-1:0] CLS_FALL   = 2'd2;

	typedef logic [D_W-1:0]    d_tab_t    [WINDOW+1];
	typedef logic [TWOD_W-1:0] twod_tab_t [WINDOW+1];
	typedef logic [K1_W-1:0]   k1_tab_t   [WINDOW+1];

	// n^2 (n^2 - 1) / 12
	function automatic d_tab_t build_d();
		d_tab_t t;
		for (int n = 0; n <= WINDOW; n++) begin
			t[n] = D_W'(n * n * (n * n - 1) / 12);
		end
		return t;
	endfunction

	function automatic twod_tab_t build_twod();
		twod_tab_t t;
		for (int n = 0; n <= WINDOW; n++) begin
			t[n] = TWOD_W'(2 * n * (n * n * (n * n - 1) / 12));
		end
		return t;
	endfunction

	// n (n - 1), twice the sum of positions
	function automatic k1_tab_t build_k1();
		k1_tab_t t;
		for (int n = 0; n <= WINDOW; n++) begin
			t[n] = K1_W'(n * (n - 1));
		end
		return t;
	endfunction

	localparam d_tab_t    D_TAB    = build_d();
	localparam twod_tab_t TWOD_TAB = build_twod();
	localparam k1_tab_t   K1_TAB   = build_k1();

endpackage

// File: hw/rtl/swte_samp_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// One sensor reading with its clear flag.
// ----------------------------------------------------------------------------
interface swte_samp_if import swte_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          clear_window;

	modport source (output valid, sample_value, clear_window, input ready);
	modport sink   (input valid, sample_value, clear_window, output ready);
endinterface

// File: hw/rtl/swte_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Slope, fitted value, forecast, class and fill for one sample.
// ----------------------------------------------------------------------------
interface swte_res_if import swte_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SLOPE_W-1:0] trend_slope;
	logic signed [15:0]        fit_newest;
	logic signed [15:0]        forecast_value;
	logic [CLS_W-1:0]          trend_class;
	logic [FILL_W-1:0]         window_fill;

	modport source (output valid, trend_slope, fit_newest, forecast_value,
		trend_class, window_fill, input ready);
	modport sink   (input valid, trend_slope, fit_newest, forecast_value,
		trend_class, window_fill, output ready);
endinterface

// File: hw/rtl/swte_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface swte_cfg_if import swte_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink   (input valid, idx, data, output ready);
endinterface

// File: hw/rtl/swte_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module swte_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 30
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hw/rtl/swte_div.sv
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Unsigned, one quotient bit per cycle; done is high for a single cycle as the last bit is registered.
// ----------------------------------------------------------------------------
module swte_div import swte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [TWOD_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);
	logic [DIV_W-1:0]     dvd_q;
	logic [TWOD_W-1:0]    rem_q;
	logic [TWOD_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TWOD_W:0]      trial;
	logic [TWOD_W:0]      diff;
	logic                 ge;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TWOD_W-1:0] : trial[TWOD_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

// File: hw/rtl/sliding_window_trend_estimator_top.sv
// ----------------------------------------------------------------------------
// Sliding-window trend estimator
// Least-squares line over the last WINDOW samples: slope, fit and forecast.
// ----------------------------------------------------------------------------
// Usage:
//  samp carries one reading (signed hundredths) and a clear flag; clear starts
//  a new series with this reading. res returns one result per request: slope
//  per minute (x256, saturated), fitted newest value, forecast, trend class
//  and fill count. cfg writes samples_per_minute, trend_threshold and
//  forecast_horizon by index; unknown indexes are dropped. cfg is always
//  ready; write it only while no request is in flight.
//  res goes valid after three 48-step divisions in turn on one radix-2 divider,
//  skipped when the window holds a single sample; samp takes one request at a
//  time and takes the next only once the last result is loaded into res.
//  Samples live in a 30-entry RAM with running sums in flops; the RAM is read
//  and written back once per request and needs no clearing after reset.
//  Reset empties the window and loads the default register values. A stalled
//  res holds its result while the next request is taken and computed; the new
//  result waits until the old one is taken.
// ----------------------------------------------------------------------------
module sliding_window_trend_estimator_top import swte_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	swte_samp_if.sink  samp,
	swte_res_if.source res,
	swte_cfg_if.sink   cfg
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UPD  = 4'd1;
	localparam logic [3:0] ST_M1   = 4'd2;
	localparam logic [3:0] ST_M2   = 4'd3;
	localparam logic [3:0] ST_M3   = 4'd4;
	localparam logic [3:0] ST_M4   = 4'd5;
	localparam logic [3:0] ST_M5   = 4'd6;
	localparam logic [3:0] ST_DS   = 4'd7;
	localparam logic [3:0] ST_DF   = 4'd8;
	localparam logic [3:0] ST_DC   = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	localparam logic signed [PTR_W:0] LAST_X = (PTR_W+1)'(WINDOW - 1);

	logic [3:0]                    state_q;
	logic [SPM_W-1:0]              spm_q;
	logic [THR_W-1:0]              thr_q;
	logic [HOR_W-1:0]              hor_q;
	logic [FILL_W-1:0]             fill_q;
	logic [PTR_W-1:0]              ptr_q;
	logic signed [SY_W-1:0]        sy_q;
	logic signed [SXY_W-1:0]       sxy_q;
	logic signed [SAMPLE_BITS-1:0] y_q;

	logic signed [SXY_W+FILL_W:0]     a_q;
	logic signed [K1_W+SY_W-1:0]      b_q;
	logic signed [NUM_W-1:0]          num_q;
	logic [K2_W-1:0]                  k2_q;
	logic signed [NUM_W+SPM_W:0]      ps_q;
	logic signed [SY_W+D_W:0]         base_q;
	logic signed [NUM_W+K1_W:0]       t1_q;
	logic signed [NUM_W+K2_W:0]       t2_q;
	logic signed [DIV_W-1:0]          fxn_q;
	logic signed [DIV_W-1:0]          fcn_q;
	logic signed [SLOPE_W-1:0]        slope_q;
	logic signed [15:0]               fit_q;
	logic signed [15:0]               fc_q;

	logic                      ov_q;
	logic signed [SLOPE_W-1:0] out_slope_q;
	logic signed [15:0]        out_fit_q;
	logic signed [15:0]        out_fc_q;
	logic [CLS_W-1:0]          out_cls_q;
	logic [FILL_W-1:0]         out_fill_q;

	logic                          samp_acc;
	logic                          ld_out;
	logic                          full;
	logic signed [SAMPLE_BITS-1:0] old_y;
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic signed [SAMPLE_BITS+FILL_W:0] xy_term;
	logic signed [SAMPLE_BITS+PTR_W:0]  y_last;
	logic [K1_W-2:0]               sx;
	logic [FILL_W+HOR_W-1:0]       nh;
	logic [NUM_W+SPM_W:0]          ps_mag;
	logic [DIV_W-1:0]              fxn_mag;
	logic [DIV_W-1:0]              fcn_mag;
	logic [DIV_W-1:0]              half;
	logic                          div_start;
	logic [DIV_W-1:0]              div_dvd;
	logic [TWOD_W-1:0]             div_dvs;
	logic                          div_done;
	logic [DIV_W-1:0]              div_q;
	logic [CLS_W-1:0]              cls;

	function automatic logic signed [SLOPE_W-1:0] sat32(input logic [DIV_W-1:0] q,
			input logic neg);
		logic signed [SLOPE_W-1:0] r;
		if (!neg) begin
			r = (q > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[SLOPE_W-1:0];
		end else begin
			r = (q > DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : -q[SLOPE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic [DIV_W-1:0] q,
			input logic neg);
		logic signed [15:0] r;
		if (!neg) begin
			r = (q > DIV_W'(16'h7FFF)) ? 16'sh7FFF : q[15:0];
		end else begin
			r = (q > DIV_W'(17'h0_8000)) ? 16'sh8000 : -q[15:0];
		end
		return r;
	endfunction

	assign samp.ready = (state_q == ST_IDLE);
	assign samp_acc   = samp.valid && samp.ready;
	assign cfg.ready  = 1'b1;
	assign ld_out     = (state_q == ST_OUT) && (!ov_q || res.ready);

	assign full    = (fill_q == FILL_W'(WINDOW));
	assign old_y   = $signed(ram_rdata);
	assign xy_term = $signed({1'b0, fill_q}) * y_q;
	assign y_last  = y_q * LAST_X;
	assign sx      = K1_TAB[fill_q][K1_W-1:1];
	assign nh      = fill_q * hor_q;
	assign half    = DIV_W'(TWOD_TAB[fill_q] >> 1);
	assign ps_mag  = ps_q[NUM_W+SPM_W] ? -ps_q : ps_q;
	assign fxn_mag = (fxn_q[DIV_W-1] ? -fxn_q : fxn_q) + half;
	assign fcn_mag = (fcn_q[DIV_W-1] ? -fcn_q : fcn_q) + half;

	swte_ram #(.W(SAMPLE_BITS), .DEPTH(WINDOW)) u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (ptr_q),
		.wdata (y_q),
		.re    (samp_acc),
		.raddr (samp.clear_window ? PTR_W'(0) : ptr_q),
		.rdata (ram_rdata)
	);

	// divider operands follow the state that starts each division
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = TWOD_TAB[fill_q];
		unique case (state_q)
			ST_M4: begin
				div_start = 1'b1;
				div_dvd   = DIV_W'({ps_mag, 8'd0});
				div_dvs   = TWOD_W'(D_TAB[fill_q]);
			end
			ST_DS: begin
				div_start = div_done;
				div_dvd   = fxn_mag;
			end
			ST_DF: begin
				div_start = div_done;
				div_dvd   = fcn_mag;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	swte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		if (slope_q > $signed({1'b0, thr_q})) begin
			cls = CLS_RISE;
		end else if (slope_q < -$signed({1'b0, thr_q})) begin
			cls = CLS_FALL;
		end else begin
			cls = CLS_STABLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spm_q <= SPM_RST;
			thr_q <= THR_RST;
			hor_q <= HOR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				REG_SPM: spm_q <= cfg.data[SPM_W-1:0];
				REG_THR: thr_q <= cfg.data[THR_W-1:0];
				REG_HOR: hor_q <= cfg.data[HOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			ptr_q   <= '0;
			sy_q    <= '0;
			sxy_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ld_out) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samp_acc) begin
						state_q <= ST_UPD;
						if (samp.clear_window) begin
							fill_q <= '0;
							ptr_q  <= '0;
							sy_q   <= '0;
							sxy_q  <= '0;
						end
					end
				end
				ST_UPD: begin
					// when full, the oldest sample drops out and every position shifts down by one
					if (!full) begin
						sxy_q  <= sxy_q + SXY_W'(xy_term);
						sy_q   <= sy_q + SY_W'(y_q);
						fill_q <= fill_q + 1'b1;
					end else begin
						sxy_q <= sxy_q - SXY_W'(sy_q) + SXY_W'(old_y) + SXY_W'(y_last);
						sy_q  <= sy_q - SY_W'(old_y) + SY_W'(y_q);
					end
					ptr_q   <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
					state_q <= ST_M1;
				end
				ST_M1: begin
					state_q <= (fill_q < FILL_W'(2)) ? ST_OUT : ST_M2;
				end
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_M5;
				ST_M5: state_q <= ST_DS;
				ST_DS: if (div_done) state_q <= ST_DF;
				ST_DF: if (div_done) state_q <= ST_DC;
				ST_DC: if (div_done) state_q <= ST_OUT;
				ST_OUT: if (ld_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (samp_acc) begin
			y_q <= samp.sample_value;
		end
		if (state_q == ST_M1) begin
			a_q     <= $signed({1'b0, fill_q}) * sxy_q;
			b_q     <= $signed({1'b0, sx}) * sy_q;
			slope_q <= '0;
			fit_q   <= y_q;
			fc_q    <= y_q;
		end
		if (state_q == ST_M2) begin
			num_q <= NUM_W'(a_q - b_q);
			k2_q  <= K2_W'(K1_TAB[fill_q]) + K2_W'({nh, 1'b0});
		end
		if (state_q == ST_M3) begin
			ps_q   <= num_q * $signed({1'b0, spm_q});
			base_q <= sy_q * $signed({1'b0, D_TAB[fill_q]});
		end
		if (state_q == ST_M4) begin
			t1_q <= num_q * $signed({1'b0, K1_TAB[fill_q]});
			t2_q <= num_q * $signed({1'b0, k2_q});
		end
		if (state_q == ST_M5) begin
			fxn_q <= (DIV_W'(base_q) <<< 1) + DIV_W'(t1_q);
			fcn_q <= (DIV_W'(base_q) <<< 1) + DIV_W'(t2_q);
		end
		if (state_q == ST_DS && div_done) begin
			slope_q <= sat32(div_q, ps_q[NUM_W+SPM_W]);
		end
		if (state_q == ST_DF && div_done) begin
			fit_q <= sat16(div_q, fxn_q[DIV_W-1]);
		end
		if (state_q == ST_DC && div_done) begin
			fc_q <= sat16(div_q, fcn_q[DIV_W-1]);
		end
		if (ld_out) begin
			out_slope_q <= slope_q;
			out_fit_q   <= fit_q;
			out_fc_q    <= fc_q;
			out_cls_q   <= cls;
			out_fill_q  <= fill_q;
		end
	end

	assign res.valid          = ov_q;
	assign res.trend_slope    = out_slope_q;
	assign res.fit_newest     = out_fit_q;
	assign res.forecast_value = out_fc_q;
	assign res.trend_class    = out_cls_q;
	assign res.window_fill    = out_fill_q;

	`include "sliding_window_trend_estimator_top_assert.svh"

	`SWTE_ASSERT_IMPL(a_fill_range, 1'b1, fill_q <= FILL_W'(WINDOW))
	`SWTE_ASSERT_IMPL(a_ptr_range, 1'b1, ptr_q < PTR_W'(WINDOW))
	`SWTE_ASSERT_NEXT(a_acc_upd, samp_acc, state_q == ST_UPD && !samp.ready)
	`SWTE_ASSERT_NEXT(a_out_load, ld_out, res.valid && state_q == ST_IDLE)
endmodule
